// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RRDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rrds check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RRDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrds check failed");

`endif

// ----- rtl/core/rrds_pkg.sv -----
// Types, constants and codes shared by the ring route direction selector.
package rrds_pkg;

  localparam int unsigned NODES_DEF = 256;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned HOP_W   = 8;
  localparam int unsigned CD_W    = 4;

  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 4;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [ID_W-1:0] NODE_ID_RST      = '0;
  localparam logic [CD_W-1:0] PROBE_PERIOD_RST = 4'd3;

  localparam logic [0:0] REG_NODE_ID      = 1'b0;
  localparam logic [0:0] REG_PROBE_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    ACT_DELIVER  = 2'd0,
    ACT_LINK     = 2'd1,
    ACT_CONSUMED = 2'd2
  } action_e;

  typedef struct packed {
    action_e              action;
    logic                 link_port;
    logic                 is_fb;
    logic [ID_W-1:0]      dst;
    logic [ID_W-1:0]      src;
    logic [ID_W-1:0]      meas;
    logic [DELAY_W-1:0]   dly;
    logic                 dir;
    logic                 wants;
    logic [HOP_W-1:0]     hop;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic second;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic two_res;
    logic clr_done;
  } sts_t;

endpackage

// ----- rtl/core/rrds_ctrl.sv -----
// Controller state machine: table clearing, item capture, execution and result issue.
module rrds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  rrds_pkg::sts_t sts_i,
  output rrds_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;
  localparam logic [1:0] ST_SECOND = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.two_res ? ST_SECOND : ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (sts_i.out_free) begin
          cmd_o.second = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/rrds_dp.sv -----
// Datapath: item registers, per-destination tables, routing decision and output register.
module rrds_dp #(
  parameter int unsigned NODES = rrds_pkg::NODES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrds_pkg::cmd_t                    cmd_i,
  output rrds_pkg::sts_t                    sts_o,
  input  logic [rrds_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  logic [rrds_pkg::S_TUSER_W-1:0]    s_tuser_i,
  input  logic [rrds_pkg::ID_W-1:0]         node_id_i,
  input  logic [rrds_pkg::CD_W-1:0]         probe_period_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rrds_pkg::result_t                 out_o
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned IW = (AW > rrds_pkg::ID_W) ? AW : rrds_pkg::ID_W;
  localparam int unsigned SW = rrds_pkg::CD_W + 2;

  // Input field extraction.
  logic                          in_fb;
  logic [rrds_pkg::ID_W-1:0]     in_dst, in_src, in_meas, in_sel;
  logic [rrds_pkg::DELAY_W-1:0]  in_dly, in_age;
  logic                          in_dir, in_wants;
  logic [rrds_pkg::HOP_W-1:0]    in_hop;
  logic [IW-1:0]                 in_sel_ext;
  logic [AW-1:0]                 in_addr;
  logic                          in_range;

  assign in_fb    = s_tuser_i[0];
  assign in_dst   = s_tdata_i[7:0];
  assign in_src   = s_tdata_i[15:8];
  assign in_meas  = s_tdata_i[23:16];
  assign in_dly   = s_tdata_i[39:24];
  assign in_dir   = s_tdata_i[40];
  assign in_wants = s_tdata_i[41];
  assign in_hop   = s_tdata_i[49:42];
  assign in_age   = s_tdata_i[65:50];

  assign in_sel     = in_fb ? in_meas : in_dst;
  assign in_sel_ext = IW'(in_sel);
  assign in_addr    = in_sel_ext[AW-1:0];
  assign in_range   = (32'(in_sel) < NODES);

  // Item registers.
  logic                          fb_q, dir_q, wants_q, inr_q;
  logic [rrds_pkg::ID_W-1:0]     dst_q, src_q, meas_q;
  logic [rrds_pkg::DELAY_W-1:0]  dly_q, age_q;
  logic [rrds_pkg::HOP_W-1:0]    hop_q;
  logic [AW-1:0]                 addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fb_q    <= in_fb;
      dst_q   <= in_dst;
      src_q   <= in_src;
      meas_q  <= in_meas;
      dly_q   <= in_dly;
      dir_q   <= in_dir;
      wants_q <= in_wants;
      hop_q   <= in_hop;
      age_q   <= in_age;
      addr_q  <= in_addr;
      inr_q   <= in_range;
    end
  end

  // Clearing pass counter.
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Tables: {known1, known0, countdown} and the two delays.
  logic [SW-1:0]                 st_mem [NODES];
  logic [rrds_pkg::DELAY_W-1:0]  d0_mem [NODES];
  logic [rrds_pkg::DELAY_W-1:0]  d1_mem [NODES];
  logic [SW-1:0]                 st_rd_q;
  logic [rrds_pkg::DELAY_W-1:0]  d0_rd_q, d1_rd_q;

  logic                          st_we, d0_we, d1_we;
  logic [SW-1:0]                 st_wd;
  logic [AW-1:0]                 st_wa;
  logic [SW-1:0]                 st_wdata;
  logic                          clr_own;
  logic [IW-1:0]                 own_rst;

  assign own_rst  = IW'(rrds_pkg::NODE_ID_RST);
  assign clr_own  = (clr_cnt_q == own_rst[AW-1:0]) &&
                    (32'(rrds_pkg::NODE_ID_RST) < NODES);
  assign st_wa    = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign st_wdata = cmd_i.clr_wr ? {clr_own, clr_own, rrds_pkg::PROBE_PERIOD_RST} : st_wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || (cmd_i.exec && st_we)) begin
      st_mem[st_wa] <= st_wdata;
    end
    if (cmd_i.exec && d0_we) begin
      d0_mem[addr_q] <= dly_q;
    end
    if (cmd_i.exec && d1_we) begin
      d1_mem[addr_q] <= dly_q;
    end
    if (cmd_i.accept) begin
      st_rd_q <= st_mem[in_addr];
      d0_rd_q <= d0_mem[in_addr];
      d1_rd_q <= d1_mem[in_addr];
    end
  end

  // Routing decision.
  logic                        rd_k0, rd_k1, nk0, nk1, way, req;
  logic [rrds_pkg::CD_W-1:0]   rd_cd, ncd;
  logic [rrds_pkg::HOP_W-1:0]  hop1;
  logic                        to_me, from_me;
  logic                        two_res;
  rrds_pkg::result_t           res0, res1;

  assign rd_cd   = st_rd_q[rrds_pkg::CD_W-1:0];
  assign rd_k0   = st_rd_q[rrds_pkg::CD_W];
  assign rd_k1   = st_rd_q[rrds_pkg::CD_W+1];
  assign hop1    = (hop_q == '1) ? hop_q : hop_q + rrds_pkg::HOP_W'(1);
  assign to_me   = (dst_q == node_id_i);
  assign from_me = (src_q == node_id_i);

  always_comb begin
    nk0 = rd_k0;
    nk1 = rd_k1;
    if (rd_cd == '0) begin
      nk0 = 1'b0;
      nk1 = 1'b0;
      ncd = probe_period_i;
    end else begin
      ncd = rd_cd - rrds_pkg::CD_W'(1);
    end
    way = 1'b1;
    req = 1'b1;
    if (inr_q) begin
      if (!nk1) begin
        way = 1'b1;
      end else if (!nk0) begin
        way = 1'b0;
      end else begin
        req = 1'b0;
        way = (d0_rd_q > d1_rd_q);
      end
    end
  end

  always_comb begin
    res0    = '0;
    res1    = '0;
    st_we   = 1'b0;
    st_wd   = st_rd_q;
    d0_we   = 1'b0;
    d1_we   = 1'b0;
    two_res = 1'b0;

    res1.action    = rrds_pkg::ACT_LINK;
    res1.link_port = 1'b1;
    res1.is_fb     = 1'b1;
    res1.dst       = src_q;
    res1.src       = node_id_i;
    res1.meas      = dst_q;
    res1.dly       = age_q;
    res1.dir       = dir_q;
    res1.last      = 1'b1;

    if (fb_q) begin
      if (to_me) begin
        res0.action = rrds_pkg::ACT_CONSUMED;
        res0.last   = 1'b1;
        if (inr_q) begin
          st_we = 1'b1;
          if (dir_q) begin
            d1_we = 1'b1;
            st_wd = {1'b1, rd_k0, rd_cd};
          end else begin
            d0_we = 1'b1;
            st_wd = {rd_k1, 1'b1, rd_cd};
          end
        end
      end else begin
        res0 = '{action: rrds_pkg::ACT_LINK, link_port: 1'b1, is_fb: 1'b1,
                 dst: dst_q, src: src_q, meas: meas_q, dly: dly_q, dir: dir_q,
                 wants: wants_q, hop: hop_q, last: 1'b1};
      end
    end else if (to_me) begin
      res0.action = rrds_pkg::ACT_DELIVER;
      res0.dst    = dst_q;
      res0.src    = src_q;
      res0.dir    = dir_q;
      res0.wants  = wants_q;
      res0.hop    = hop_q;
      res0.last   = !wants_q;
      two_res     = wants_q;
    end else if (!from_me) begin
      res0.action    = rrds_pkg::ACT_LINK;
      res0.link_port = dir_q;
      res0.dst       = dst_q;
      res0.src       = src_q;
      res0.dir       = dir_q;
      res0.wants     = wants_q;
      res0.hop       = hop1;
      res0.last      = 1'b1;
    end else begin
      res0.action    = rrds_pkg::ACT_LINK;
      res0.link_port = way;
      res0.dst       = dst_q;
      res0.src       = src_q;
      res0.dir       = way;
      res0.wants     = req;
      res0.hop       = hop1;
      res0.last      = 1'b1;
      st_we          = inr_q;
      st_wd          = {nk1, nk0, ncd};
    end
  end

  // Output register.
  logic              out_valid_q;
  rrds_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.second) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= res0;
    end else if (cmd_i.second) begin
      out_q <= res1;
    end
  end

  assign sts_o       = '{out_free: !out_valid_q || out_ready_i,
                         two_res:  two_res,
                         clr_done: (clr_cnt_q == AW'(NODES - 1))};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/ring_route_direction_selector_top.sv -----
// Top level of the ring route direction selector: stream ports, register port, core.
//
//   channel   | dir | handshake                 | carries
//   s_axis    | in  | s_axis_tvalid/tready      | one packet item
//   m_axis    | out | m_axis_tvalid/tready      | one or two result items per packet
//   apb       | in  | psel/penable, pready = 1  | node_id (0x0), probe_period (0x4)
//
// An item is captured with the table read, then executed with the table write-back.
// A delivered packet that asks for feedback emits a second item as the next output item.
// The single-port per-destination state table sets the rate (read-modify-write per item).
// After reset a clearing pass writes every entry of the state table; s_axis_tready
// stays low during it. A stalled m_axis holds the result and execution waits for it.
module ring_route_direction_selector_top #(
  parameter int unsigned NODES = rrds_pkg::NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // destination[7:0] source[15:8] measured_node[23:16] delay[39:24] direction[40]
  // wants_feedback[41] hop_count[49:42] packet_age[65:50]
  input  logic [rrds_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // is_feedback[0]
  input  logic [rrds_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_destination[7:0] out_source[15:8] out_measured_node[23:16] out_delay[39:24]
  // out_direction[40] out_wants_feedback[41] out_hop_count[49:42]
  output logic [rrds_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // action[1:0] link_port[2] out_is_feedback[3]
  output logic [rrds_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrds_pkg::APB_AW-1:0]    paddr,
  input  logic [rrds_pkg::APB_DW-1:0]    pwdata,
  output logic [rrds_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  logic [rrds_pkg::ID_W-1:0] node_id_q;
  logic [rrds_pkg::CD_W-1:0] probe_period_q;
  logic                      cfg_we;
  logic [0:0]                reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= rrds_pkg::NODE_ID_RST;
      probe_period_q <= rrds_pkg::PROBE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        rrds_pkg::REG_NODE_ID:      node_id_q      <= pwdata[rrds_pkg::ID_W-1:0];
        rrds_pkg::REG_PROBE_PERIOD: probe_period_q <= pwdata[rrds_pkg::CD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rrds_pkg::REG_NODE_ID:      prdata = rrds_pkg::APB_DW'(node_id_q);
      rrds_pkg::REG_PROBE_PERIOD: prdata = rrds_pkg::APB_DW'(probe_period_q);
      default:                    prdata = '0;
    endcase
  end

  rrds_pkg::cmd_t    cmd;
  rrds_pkg::sts_t    sts;
  rrds_pkg::result_t res;

  rrds_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rrds_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .s_tdata_i      (s_axis_tdata_i),
    .s_tuser_i      (s_axis_tuser_i),
    .node_id_i      (node_id_q),
    .probe_period_i (probe_period_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_o          (res)
  );

  assign m_axis_tdata_o = {6'b0, res.hop, res.wants, res.dir, res.dly,
                           res.meas, res.src, res.dst};
  assign m_axis_tuser_o = {res.is_fb, res.link_port, res.action};
  assign m_axis_tlast_o = res.last;

endmodule

// ----- rtl/core/rrds_checker.sv -----
// Port-level checker for the ring route direction selector, bound to the top level.
`include "assert_macros.svh"

module rrds_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_i,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [rrds_pkg::M_TDATA_W-1:0] m_tdata_i,
  input logic [rrds_pkg::M_TUSER_W-1:0] m_tuser_i,
  input logic                           m_tlast_i
);

  `RRDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
  `RRDS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i)
  `RRDS_ASSERT(a_consumed_empty, clk_i, rst_ni, (m_tvalid_i && m_tuser_i[1:0] == rrds_pkg::ACT_CONSUMED) |-> (m_tdata_i == '0 && m_tlast_i))
  `RRDS_ASSERT_NEXT(a_feedback_follows, clk_i, rst_ni, m_tvalid_i && m_tready_i && !m_tlast_i, m_tvalid_i && m_tuser_i[3] && m_tuser_i[2] && m_tlast_i)

endmodule

bind ring_route_direction_selector_top rrds_checker u_rrds_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench of the ring route direction selector: directed packet table, then random traffic.
module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned RAND_PER_PHASE = 150;
  localparam int unsigned PHASES         = 5;
  localparam int unsigned POOL_SIZE      = 6;

  localparam logic [rrds_pkg::APB_AW-1:0] ADDR_NODE_ID      = {rrds_pkg::REG_NODE_ID, 2'b00};
  localparam logic [rrds_pkg::APB_AW-1:0] ADDR_PROBE_PERIOD =
    {rrds_pkg::REG_PROBE_PERIOD, 2'b00};

  localparam logic [rrds_pkg::ID_W-1:0] PHASE_NODE [PHASES] =
    '{8'h5A, 8'hFF, 8'h01, 8'h00, 8'h80};
  localparam logic [rrds_pkg::CD_W-1:0] PHASE_PERIOD [PHASES] =
    '{4'h0, 4'hF, 4'h1, 4'h7, 4'h2};

  typedef struct packed {
    logic                         is_fb;
    logic [rrds_pkg::ID_W-1:0]    dst;
    logic [rrds_pkg::ID_W-1:0]    src;
    logic [rrds_pkg::ID_W-1:0]    meas;
    logic [rrds_pkg::DELAY_W-1:0] dly;
    logic                         dir;
    logic                         wants;
    logic [rrds_pkg::HOP_W-1:0]   hop;
    logic [rrds_pkg::DELAY_W-1:0] age;
  } packet_t;

  typedef struct packed {
    logic              typed;
    packet_t           pkt;
    rrds_pkg::result_t res;
  } row_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [rrds_pkg::S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [rrds_pkg::S_TUSER_W-1:0] s_axis_tuser_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [rrds_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic [rrds_pkg::M_TUSER_W-1:0] m_axis_tuser_o;
  logic                           m_axis_tlast_o;
  logic                           psel            = 1'b0;
  logic                           penable         = 1'b0;
  logic                           pwrite          = 1'b0;
  logic [rrds_pkg::APB_AW-1:0]    paddr           = '0;
  logic [rrds_pkg::APB_DW-1:0]    pwdata          = '0;
  logic [rrds_pkg::APB_DW-1:0]    prdata;
  logic                           pready;

  ring_route_direction_selector_top #(
    .NODES(rrds_pkg::NODES_DEF)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk_i = ~clk_i;

  logic [rrds_pkg::DELAY_W-1:0] way0_delay [rrds_pkg::NODES_DEF];
  logic [rrds_pkg::DELAY_W-1:0] way1_delay [rrds_pkg::NODES_DEF];
  logic                         way0_known [rrds_pkg::NODES_DEF];
  logic                         way1_known [rrds_pkg::NODES_DEF];
  logic [rrds_pkg::CD_W-1:0]    probes_left [rrds_pkg::NODES_DEF];
  logic [rrds_pkg::ID_W-1:0]    my_id;
  logic [rrds_pkg::CD_W-1:0]    my_period;

  rrds_pkg::result_t         route_q [$];
  row_t                      directed_rows [$];
  logic [rrds_pkg::ID_W-1:0] dest_pool [POOL_SIZE];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_cnt;
  int unsigned packets_sent;
  int unsigned results_seen;
  int unsigned settings_cnt;
  int unsigned cycle_cnt;

  function automatic rrds_pkg::result_t make_result(rrds_pkg::action_e a, logic port, logic fb,
                                                    logic [rrds_pkg::ID_W-1:0] dst,
                                                    logic [rrds_pkg::ID_W-1:0] src,
                                                    logic [rrds_pkg::ID_W-1:0] meas,
                                                    logic [rrds_pkg::DELAY_W-1:0] dly,
                                                    logic dir, logic wants,
                                                    logic [rrds_pkg::HOP_W-1:0] hop,
                                                    logic last);
    rrds_pkg::result_t r;
    r.action    = a;
    r.link_port = port;
    r.is_fb     = fb;
    r.dst       = dst;
    r.src       = src;
    r.meas      = meas;
    r.dly       = dly;
    r.dir       = dir;
    r.wants     = wants;
    r.hop       = hop;
    r.last      = last;
    return r;
  endfunction

  function automatic packet_t make_packet(logic fb, logic [rrds_pkg::ID_W-1:0] dst,
                                          logic [rrds_pkg::ID_W-1:0] src,
                                          logic [rrds_pkg::ID_W-1:0] meas,
                                          logic [rrds_pkg::DELAY_W-1:0] dly,
                                          logic dir, logic wants,
                                          logic [rrds_pkg::HOP_W-1:0] hop,
                                          logic [rrds_pkg::DELAY_W-1:0] age);
    packet_t p;
    p.is_fb = fb;
    p.dst   = dst;
    p.src   = src;
    p.meas  = meas;
    p.dly   = dly;
    p.dir   = dir;
    p.wants = wants;
    p.hop   = hop;
    p.age   = age;
    return p;
  endfunction

  function automatic packet_t random_packet();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(packet_t)-1:0];
  endfunction

  // Route one packet through the table copy; return how many results it emits.
  function automatic int route_packet(input packet_t p, output rrds_pkg::result_t r0,
                                      output rrds_pkg::result_t r1);
    logic [rrds_pkg::HOP_W-1:0] hop_next;
    logic                       way;
    logic                       req;
    int                         n;
    hop_next = (p.hop == '1) ? p.hop : p.hop + rrds_pkg::HOP_W'(1);
    r0 = '0;
    r1 = '0;
    n  = 1;
    if (p.is_fb) begin
      if (p.dst == my_id) begin
        if (p.dir) begin
          way1_delay[p.meas] = p.dly;
          way1_known[p.meas] = 1'b1;
        end else begin
          way0_delay[p.meas] = p.dly;
          way0_known[p.meas] = 1'b1;
        end
        r0 = make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, '0,
                         1'b1);
      end else begin
        r0 = make_result(rrds_pkg::ACT_LINK, 1'b1, 1'b1, p.dst, p.src, p.meas, p.dly, p.dir,
                         p.wants, p.hop, 1'b1);
      end
    end else if (p.dst == my_id) begin
      r0 = make_result(rrds_pkg::ACT_DELIVER, 1'b0, 1'b0, p.dst, p.src, '0, '0, p.dir,
                       p.wants, p.hop, !p.wants);
      if (p.wants) begin
        r1 = make_result(rrds_pkg::ACT_LINK, 1'b1, 1'b1, p.src, my_id, p.dst, p.age, p.dir,
                         1'b0, '0, 1'b1);
        n  = 2;
      end
    end else if (p.src != my_id) begin
      r0 = make_result(rrds_pkg::ACT_LINK, p.dir, 1'b0, p.dst, p.src, '0, '0, p.dir, p.wants,
                       hop_next, 1'b1);
    end else begin
      if (probes_left[p.dst] == '0) begin
        way0_known[p.dst]  = 1'b0;
        way1_known[p.dst]  = 1'b0;
        probes_left[p.dst] = my_period;
      end else begin
        probes_left[p.dst] = probes_left[p.dst] - rrds_pkg::CD_W'(1);
      end
      req = 1'b1;
      if (!way1_known[p.dst]) begin
        way = 1'b1;
      end else if (!way0_known[p.dst]) begin
        way = 1'b0;
      end else begin
        req = 1'b0;
        way = way0_delay[p.dst] > way1_delay[p.dst];
      end
      r0 = make_result(rrds_pkg::ACT_LINK, way, 1'b0, p.dst, p.src, '0, '0, way, req,
                       hop_next, 1'b1);
    end
    return n;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic send_packet(input packet_t p, input logic typed,
                             input rrds_pkg::result_t typed_res);
    rrds_pkg::result_t r0;
    rrds_pkg::result_t r1;
    int                n;
    logic              taken;
    n = route_packet(p, r0, r1);
    route_q.push_back(typed ? typed_res : r0);
    if (n == 2) route_q.push_back(r1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, p.age, p.hop, p.wants, p.dir, p.dly, p.meas, p.src, p.dst};
    s_axis_tuser_i  <= p.is_fb;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    packets_sent++;
  endtask

  task automatic send_random(input packet_t p);
    send_packet(p, 1'b0, '0);
  endtask

  task automatic add_row(input logic typed, input packet_t p, input rrds_pkg::result_t r);
    row_t row;
    row.typed = typed;
    row.pkt   = p;
    row.res   = r;
    directed_rows.push_back(row);
  endtask

  task automatic apb_access(input logic wr, input logic [rrds_pkg::APB_AW-1:0] addr,
                            input logic [rrds_pkg::APB_DW-1:0] wdata,
                            output logic [rrds_pkg::APB_DW-1:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done  = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_regs();
    logic [rrds_pkg::APB_DW-1:0] rd;
    apb_access(1'b0, ADDR_NODE_ID, '0, rd);
    check_field("node_id", 32'(my_id), rd);
    apb_access(1'b0, ADDR_PROBE_PERIOD, '0, rd);
    check_field("probe_period", 32'(my_period), rd);
  endtask

  task automatic apply_config(input logic [rrds_pkg::ID_W-1:0] node,
                              input logic [rrds_pkg::CD_W-1:0] period);
    logic [rrds_pkg::APB_DW-1:0] rd;
    apb_access(1'b1, ADDR_NODE_ID, 32'(node), rd);
    my_id = node;
    apb_access(1'b1, ADDR_PROBE_PERIOD, 32'(period), rd);
    my_period = period;
    settings_cnt++;
    check_regs();
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 25;
        recv_idle_pct = 58;
      end
      1: begin
        send_idle_pct = 58;
        recv_idle_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned                  start;
    int unsigned                  kind;
    packet_t                      p;
    logic [rrds_pkg::ID_W-1:0]    d;
    logic [rrds_pkg::DELAY_W-1:0] dl0;
    logic [rrds_pkg::DELAY_W-1:0] dl1;
    start = packets_sent;
    while (packets_sent - start < count) begin
      kind = $urandom_range(0, 9);
      p    = random_packet();
      if (kind < 4) begin
        d   = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
        dl0 = rrds_pkg::DELAY_W'($urandom);
        dl1 = ($urandom_range(0, 3) == 0) ? dl0 : rrds_pkg::DELAY_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          p = random_packet();
          p.is_fb = 1'b1; p.dst = my_id; p.meas = d; p.dly = dl0; p.dir = 1'b0;
          send_random(p);
        end
        if ($urandom_range(0, 3) != 0) begin
          p = random_packet();
          p.is_fb = 1'b1; p.dst = my_id; p.meas = d; p.dly = dl1; p.dir = 1'b1;
          send_random(p);
        end
        repeat ($urandom_range(1, 6)) begin
          p = random_packet();
          p.is_fb = 1'b0; p.src = my_id; p.dst = d;
          send_random(p);
        end
      end else begin
        case (kind)
          4, 5: begin
            p.is_fb = 1'b0;
            p.src   = my_id;
          end
          6: begin
            p.is_fb = 1'b0;
            p.dst   = my_id;
          end
          7: begin
            p.is_fb = 1'b1;
            p.dst   = my_id;
          end
          default: ;
        endcase
        send_random(p);
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(negedge clk_i) begin
    rrds_pkg::result_t want;
    rrds_pkg::result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.action    = rrds_pkg::action_e'(m_axis_tuser_o[1:0]);
      got.link_port = m_axis_tuser_o[2];
      got.is_fb     = m_axis_tuser_o[3];
      got.dst       = m_axis_tdata_o[7:0];
      got.src       = m_axis_tdata_o[15:8];
      got.meas      = m_axis_tdata_o[23:16];
      got.dly       = m_axis_tdata_o[39:24];
      got.dir       = m_axis_tdata_o[40];
      got.wants     = m_axis_tdata_o[41];
      got.hop       = m_axis_tdata_o[49:42];
      got.last      = m_axis_tlast_o;
      results_seen++;
      if (route_q.size() == 0) begin
        $error("result item with no packet pending: tuser %h tdata %h", m_axis_tuser_o,
               m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = route_q.pop_front();
        check_field("action", 32'(want.action), 32'(got.action));
        check_field("link_port", 32'(want.link_port), 32'(got.link_port));
        check_field("out_is_feedback", 32'(want.is_fb), 32'(got.is_fb));
        check_field("out_destination", 32'(want.dst), 32'(got.dst));
        check_field("out_source", 32'(want.src), 32'(got.src));
        check_field("out_measured_node", 32'(want.meas), 32'(got.meas));
        check_field("out_delay", 32'(want.dly), 32'(got.dly));
        check_field("out_direction", 32'(want.dir), 32'(got.dir));
        check_field("out_wants_feedback", 32'(want.wants), 32'(got.wants));
        check_field("out_hop_count", 32'(want.hop), 32'(got.hop));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("ring_route_direction_selector_top: mismatch");
    $finish;
  end

  initial begin
    fail_cnt     = 0;
    packets_sent = 0;
    results_seen = 0;
    settings_cnt = 0;
    my_id        = rrds_pkg::NODE_ID_RST;
    my_period    = rrds_pkg::PROBE_PERIOD_RST;
    for (int i = 0; i < rrds_pkg::NODES_DEF; i++) begin
      way0_delay[i]  = '0;
      way1_delay[i]  = '0;
      way0_known[i]  = 1'b0;
      way1_known[i]  = 1'b0;
      probes_left[i] = rrds_pkg::PROBE_PERIOD_RST;
    end
    way0_known[rrds_pkg::NODE_ID_RST] = 1'b1;
    way1_known[rrds_pkg::NODE_ID_RST] = 1'b1;
    set_idling(0);

    // write the own entry first so no compare ever reads a delay left from reset
    add_row(1'b1, make_packet(1'b1, 8'h00, 8'h09, 8'h00, 16'h1234, 1'b0, 1'b0, 8'h00, 16'h0000),
            make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                        1'b0, 1'b0, 8'h00, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'h00, 8'h09, 8'h00, 16'hFFFF, 1'b1, 1'b0, 8'h00, 16'h0000),
            make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                        1'b0, 1'b0, 8'h00, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF),
            make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                        1'b0, 1'b0, 8'h00, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'hFF, 8'hAA, 8'h55, 16'hA5A5, 1'b0, 1'b1, 8'hFF, 16'h0000),
            make_result(rrds_pkg::ACT_LINK, 1'b1, 1'b1, 8'hFF, 8'hAA, 8'h55, 16'hA5A5,
                        1'b0, 1'b1, 8'hFF, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'h01, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 16'hFFFF),
            make_result(rrds_pkg::ACT_LINK, 1'b1, 1'b1, 8'h01, 8'h00, 8'h00, 16'h0000,
                        1'b1, 1'b0, 8'h00, 1'b1));
    add_row(1'b1, make_packet(1'b0, 8'h00, 8'h80, 8'h77, 16'h7777, 1'b1, 1'b0, 8'hFF, 16'h1111),
            make_result(rrds_pkg::ACT_DELIVER, 1'b0, 1'b0, 8'h00, 8'h80, 8'h00, 16'h0000,
                        1'b1, 1'b0, 8'hFF, 1'b1));
    add_row(1'b0, make_packet(1'b0, 8'h00, 8'h42, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h07, 16'hFFFF),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h10, 8'h20, 8'h33, 16'h3333, 1'b0, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h11, 8'h21, 8'h00, 16'h0000, 1'b1, 1'b1, 8'hFE, 16'h0000),
            '0);
    add_row(1'b1, make_packet(1'b0, 8'hFE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF),
            make_result(rrds_pkg::ACT_LINK, 1'b1, 1'b0, 8'hFE, 8'hFF, 8'h00, 16'h0000,
                        1'b1, 1'b1, 8'hFF, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'h00, 8'h30, 8'h30, 16'd100, 1'b0, 1'b0, 8'h00, 16'h0000),
            make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                        1'b0, 1'b0, 8'h00, 1'b1));
    add_row(1'b1, make_packet(1'b1, 8'h00, 8'h30, 8'h30, 16'd100, 1'b1, 1'b0, 8'h00, 16'h0000),
            make_result(rrds_pkg::ACT_CONSUMED, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                        1'b0, 1'b0, 8'h00, 1'b1));
    repeat (5) begin
      add_row(1'b0, make_packet(1'b0, 8'h30, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h03,
                                16'h0000), '0);
    end
    add_row(1'b0, make_packet(1'b0, 8'h31, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b1, 8'h00, 8'h31, 8'h31, 16'd5, 1'b1, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h31, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b1, 8'h00, 8'h31, 8'h31, 16'd9, 1'b0, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h31, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b1, 8'h00, 8'h31, 8'h31, 16'd3, 1'b0, 1'b0, 8'h00, 16'h0000),
            '0);
    add_row(1'b0, make_packet(1'b0, 8'h31, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h00, 16'h0000),
            '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    foreach (directed_rows[i]) begin
      send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      apply_config(PHASE_NODE[ph], PHASE_PERIOD[ph]);
      set_idling((ph < 2) ? 0 : (ph < 4) ? 1 : 2);
      foreach (dest_pool[i]) dest_pool[i] = rrds_pkg::ID_W'($urandom_range(0, 255));
      run_random(RAND_PER_PHASE);
    end
    wait_drained();

    $display("%0d packets sent, %0d result items checked, %0d register settings applied",
             packets_sent, results_seen, settings_cnt);
    $display("idle mixes: sender 25/receiver 58, sender 58/receiver 25, then back-to-back");
    if (fail_cnt == 0 && route_q.size() == 0) begin
      $display("ring_route_direction_selector_top: match");
    end else begin
      $display("ring_route_direction_selector_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rrds_pkg.sv
rtl/core/rrds_ctrl.sv
rtl/core/rrds_dp.sv
rtl/core/ring_route_direction_selector_top.sv
rtl/core/rrds_checker.sv
verif/tb_top.sv
